/* rtl/core/thermistor_table_interpolation_core_defines.svh */
// Assertion macros used by the checker file of the thermistor table interpolation core.
`ifndef THERMISTOR_TABLE_INTERPOLATION_CORE_DEFINES_SVH
`define THERMISTOR_TABLE_INTERPOLATION_CORE_DEFINES_SVH

// Concurrent assertion on a given clock, disabled while the given active-low reset is low.
`define TTIC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same assertion on the standard clock and reset port names.
`define TTIC_ASSERT_STD(lbl, prop, msg) \
  `TTIC_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

/* rtl/core/ttic_pkg.sv */
// Package with the constants, types and helpers of the thermistor table interpolation core.
`timescale 1ns / 1ps
`default_nettype none

package ttic_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int SAMPLE_BITS = 12;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int TEMP_W      = 18;
  localparam int PADDR_W     = 3;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int FRAC_W      = 8;
  localparam int DIV_CNT_W   = $clog2(FRAC_W);

  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic signed [7:0] BASE_TEMP_RESET = -8'sd20;
  localparam logic [7:0] LAST_INDEX_RESET = 8'd170;

  typedef enum logic {
    MODE_CONVERT = 1'b0,
    MODE_WRITE   = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_COLD   = 2'd1,
    ST_HOT    = 2'd2,
    ST_WRITE  = 2'd3
  } status_e;

  typedef enum logic {
    REG_BASE_TEMP  = 1'b0,
    REG_LAST_INDEX = 1'b1
  } reg_addr_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_START,
    BS_FIRST,
    BS_LAST,
    BS_SCAN,
    BS_DIV,
    BS_DONE
  } back_state_e;

  typedef struct packed {
    mode_e                  kind;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   wr_ok;
    logic [IDX_W-1:0]       waddr;
    logic [SAMPLE_BITS-1:0] wval;
  } cmd_t;

  typedef struct packed {
    logic signed [7:0] base_temp;
    logic [7:0]        last_index;
  } cfg_t;

  function automatic logic [IDX_W-1:0] to_idx(input logic [31:0] v);
    return v[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ttic_if.sv */
// Stream interfaces for the input items and the result items of the core.
`timescale 1ns / 1ps
`default_nettype none

interface ttic_in_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [ttic_pkg::SAMPLE_BITS-1:0] sample;
  logic [7:0]                      entry_index;
  logic [ttic_pkg::SAMPLE_BITS-1:0] entry_value;

  modport source(output valid, output mode, output sample, output entry_index,
                 output entry_value, input ready);
  modport sink(input valid, input mode, input sample, input entry_index,
               input entry_value, output ready);
endinterface

interface ttic_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ttic_pkg::TEMP_W-1:0] temperature_q8;
  logic [1:0]                          range_status;
  logic [7:0]                          segment_index;

  modport source(output valid, output temperature_q8, output range_status,
                 output segment_index, input ready);
  modport sink(input valid, input temperature_q8, input range_status,
               input segment_index, output ready);
endinterface

`default_nettype wire

/* rtl/core/ttic_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ttic_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/ttic_front.sv */
// Front end: accepts input transfers, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module ttic_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  ttic_in_if.sink        in_i,
  output logic           head_valid_o,
  output ttic_pkg::cmd_t head_o,
  input  logic           pop_i
);

  ttic_pkg::cmd_t                      fifo_q [ttic_pkg::FIFO_DEPTH];
  logic [ttic_pkg::FIFO_PTR_W-1:0]     wr_ptr_q;
  logic [ttic_pkg::FIFO_PTR_W-1:0]     rd_ptr_q;
  logic [ttic_pkg::FIFO_CNT_W-1:0]     count_q;
  logic [ttic_pkg::FIFO_CNT_W-1:0]     count_d;
  logic                                push;
  logic                                pop;
  ttic_pkg::cmd_t                      cmd;

  assign in_i.ready   = (count_q != ttic_pkg::FIFO_CNT_W'(ttic_pkg::FIFO_DEPTH));
  assign push         = in_i.valid && in_i.ready;
  assign head_valid_o = (count_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = fifo_q[rd_ptr_q];

  always_comb begin
    cmd.kind   = (in_i.mode == ttic_pkg::MODE_WRITE) ? ttic_pkg::MODE_WRITE
                                                      : ttic_pkg::MODE_CONVERT;
    cmd.sample = in_i.sample;
    cmd.wr_ok  = ({24'd0, in_i.entry_index} < 32'(ttic_pkg::TABLE_DEPTH));
    cmd.waddr  = ttic_pkg::to_idx({24'd0, in_i.entry_index});
    cmd.wval   = in_i.entry_value;
  end

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ttic_back.sv */
// Back end: table writes, clamp checks, segment scan, fraction divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module ttic_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ttic_pkg::cfg_t cfg_i,
  input  logic           head_valid_i,
  input  ttic_pkg::cmd_t head_i,
  output logic           pop_o,
  ttic_out_if.source     out_o
);

  localparam int SB = ttic_pkg::SAMPLE_BITS;
  localparam int IW = ttic_pkg::IDX_W;
  localparam int TW = ttic_pkg::TEMP_W;

  ttic_pkg::back_state_e state_q;
  ttic_pkg::back_state_e state_d;

  ttic_pkg::cmd_t                cmd_q;
  logic [IW-1:0]                 idx_q;
  logic [IW-1:0]                 seg_q;
  logic [SB-1:0]                 prev_q;
  logic [SB-1:0]                 rem_q;
  logic [SB-1:0]                 den_q;
  logic [ttic_pkg::FRAC_W-1:0]   quo_q;
  logic [ttic_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [TW-1:0]                 res_temp_q;
  ttic_pkg::status_e             res_status_q;
  logic [IW-1:0]                 res_seg_q;
  logic                          out_valid_q;

  logic                          ram_we;
  logic [IW-1:0]                 ram_raddr;
  logic [SB-1:0]                 rd_data;
  logic                          out_load;

  logic [31:0]                   last_w;
  logic [IW-1:0]                 last_idx;
  logic [TW-1:0]                 base_ext;
  logic [TW-1:0]                 cold_sum;
  logic [TW-1:0]                 hot_sum;
  logic [TW-1:0]                 seg_sum;
  logic [SB:0]                   rem_shift;
  logic [SB:0]                   rem_diff;
  logic                          div_bit;
  logic [SB-1:0]                 rem_next;
  logic [31:0]                   seg_w;
  logic                          hit_cold;
  logic                          hit_hot;
  logic                          hit_seg;
  logic                          div_last;

  ttic_ram #(
    .WIDTH(SB),
    .DEPTH(ttic_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cmd_q.waddr),
    .wdata_i(cmd_q.wval),
    .raddr_i(ram_raddr),
    .rdata_o(rd_data)
  );

  assign last_w   = {24'd0, cfg_i.last_index};
  assign last_idx = (last_w >= 32'(ttic_pkg::TABLE_DEPTH)) ? ttic_pkg::IDX_MAX
                                                           : ttic_pkg::to_idx(last_w);
  assign base_ext = {{(TW - 8){cfg_i.base_temp[7]}}, cfg_i.base_temp};
  assign cold_sum = base_ext;
  assign hot_sum  = base_ext + TW'(last_idx);
  assign seg_sum  = base_ext + TW'(seg_q);

  assign hit_cold = (cmd_q.sample >= rd_data);
  assign hit_hot  = (cmd_q.sample <= rd_data);
  assign hit_seg  = (cmd_q.sample > rd_data);
  assign div_last = (cnt_q == ttic_pkg::DIV_CNT_W'(ttic_pkg::FRAC_W - 1));

  assign rem_shift = {rem_q, 1'b0};
  assign rem_diff  = rem_shift - {1'b0, den_q};
  assign div_bit   = (rem_shift >= {1'b0, den_q});
  assign rem_next  = div_bit ? rem_diff[SB-1:0] : rem_shift[SB-1:0];
  assign seg_w     = 32'(res_seg_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ttic_pkg::BS_IDLE: begin
        if (head_valid_i) begin
          state_d = ttic_pkg::BS_START;
        end
      end
      ttic_pkg::BS_START: begin
        state_d = (cmd_q.kind == ttic_pkg::MODE_WRITE) ? ttic_pkg::BS_DONE
                                                        : ttic_pkg::BS_FIRST;
      end
      ttic_pkg::BS_FIRST: begin
        state_d = hit_cold ? ttic_pkg::BS_DONE : ttic_pkg::BS_LAST;
      end
      ttic_pkg::BS_LAST: begin
        state_d = hit_hot ? ttic_pkg::BS_DONE : ttic_pkg::BS_SCAN;
      end
      ttic_pkg::BS_SCAN: begin
        if (hit_seg) begin
          state_d = ttic_pkg::BS_DIV;
        end
      end
      ttic_pkg::BS_DIV: begin
        if (div_last) begin
          state_d = ttic_pkg::BS_DONE;
        end
      end
      ttic_pkg::BS_DONE: begin
        if (out_load) begin
          state_d = ttic_pkg::BS_IDLE;
        end
      end
      default: begin
        state_d = ttic_pkg::BS_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = '0;
    out_load  = 1'b0;
    case (state_q)
      ttic_pkg::BS_IDLE: begin
        pop_o = head_valid_i;
      end
      ttic_pkg::BS_START: begin
        ram_we    = (cmd_q.kind == ttic_pkg::MODE_WRITE) && cmd_q.wr_ok;
        ram_raddr = '0;
      end
      ttic_pkg::BS_FIRST: begin
        ram_raddr = last_idx;
      end
      ttic_pkg::BS_LAST: begin
        ram_raddr = ttic_pkg::to_idx(32'd1);
      end
      ttic_pkg::BS_SCAN: begin
        ram_raddr = idx_q + 1'b1;
      end
      ttic_pkg::BS_DONE: begin
        out_load = !out_valid_q || out_o.ready;
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttic_pkg::BS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ttic_pkg::BS_IDLE: begin
        if (head_valid_i) begin
          cmd_q <= head_i;
        end
      end
      ttic_pkg::BS_START: begin
        res_status_q <= ttic_pkg::ST_WRITE;
        res_temp_q   <= '0;
        res_seg_q    <= '0;
      end
      ttic_pkg::BS_FIRST: begin
        prev_q       <= rd_data;
        res_status_q <= ttic_pkg::ST_COLD;
        res_temp_q   <= {cold_sum[TW-9:0], 8'd0};
        res_seg_q    <= '0;
      end
      ttic_pkg::BS_LAST: begin
        res_status_q <= ttic_pkg::ST_HOT;
        res_temp_q   <= {hot_sum[TW-9:0], 8'd0};
        res_seg_q    <= '0;
        idx_q        <= ttic_pkg::to_idx(32'd1);
      end
      ttic_pkg::BS_SCAN: begin
        if (hit_seg) begin
          seg_q <= idx_q - 1'b1;
          rem_q <= prev_q - cmd_q.sample;
          den_q <= prev_q - rd_data;
          quo_q <= '0;
          cnt_q <= '0;
        end else begin
          prev_q <= rd_data;
          idx_q  <= idx_q + 1'b1;
        end
      end
      ttic_pkg::BS_DIV: begin
        rem_q <= rem_next;
        quo_q <= {quo_q[ttic_pkg::FRAC_W-2:0], div_bit};
        cnt_q <= cnt_q + 1'b1;
        if (div_last) begin
          res_status_q <= ttic_pkg::ST_INTERP;
          res_seg_q    <= seg_q;
          res_temp_q   <= {seg_sum[TW-9:0], quo_q[ttic_pkg::FRAC_W-2:0], div_bit};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.temperature_q8 <= res_temp_q;
      out_o.range_status   <= res_status_q;
      out_o.segment_index  <= seg_w[7:0];
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/thermistor_table_interpolation_core.sv */
// A table write passes the start and done states; a conversion checks the cold clamp on
// entry 0 and the hot clamp on the last entry, then scans segments and runs the divider.
// The back end handles one item at a time, so a new item starts only when the last is done,
// its pace set by the linear segment scan (one table entry per cycle) and the 8-bit divider.
// A two-entry queue and the result register let input and output stall independently.
// Reset clears control state and sets the base to -20 and the last index to 170.
`timescale 1ns / 1ps
`default_nettype none

module thermistor_table_interpolation_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ttic_in_if.sink                      in_i,
  ttic_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ttic_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  ttic_pkg::cfg_t cfg_q;
  logic           cfg_we;
  logic           head_valid;
  ttic_pkg::cmd_t head;
  logic           pop;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_temp  <= ttic_pkg::BASE_TEMP_RESET;
      cfg_q.last_index <= ttic_pkg::LAST_INDEX_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == ttic_pkg::REG_LAST_INDEX) begin
        cfg_q.last_index <= pwdata[7:0];
      end else begin
        cfg_q.base_temp <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == ttic_pkg::REG_LAST_INDEX) ? {24'd0, cfg_q.last_index}
                                                         : {24'd0, cfg_q.base_temp};

  ttic_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  ttic_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

/* rtl/core/ttic_checker.sv */
// Port-level assertion checker for the thermistor table interpolation core and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "thermistor_table_interpolation_core_defines.svh"

module ttic_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [ttic_pkg::TEMP_W-1:0]  temperature_q8_i,
  input logic [1:0]                   range_status_i,
  input logic [7:0]                   segment_index_i
);

  `TTIC_ASSERT_STD(a_out_hold, (out_valid_i && !out_ready_i) |=> out_valid_i,
                   "result dropped while stalled")

  `TTIC_ASSERT_STD(a_write_zero,
                   (out_valid_i && (range_status_i == ttic_pkg::ST_WRITE)) |->
                   ((temperature_q8_i == '0) && (segment_index_i == '0)),
                   "table write result not zero")

  `TTIC_ASSERT_STD(a_clamp_whole,
                   (out_valid_i && ((range_status_i == ttic_pkg::ST_COLD) ||
                                    (range_status_i == ttic_pkg::ST_HOT))) |->
                   ((temperature_q8_i[7:0] == 8'd0) && (segment_index_i == 8'd0)),
                   "clamped result has fraction or segment")

endmodule

bind thermistor_table_interpolation_core ttic_checker u_ttic_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .temperature_q8_i(out_o.temperature_q8),
  .range_status_i  (out_o.range_status),
  .segment_index_i (out_o.segment_index)
);

`default_nettype wire
